// ===== design/lce_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types, codes and the gamma table generator for the LED command
// encoder.
// ----------------------------------------------------------------------------
package lce_pkg;

  localparam int GAMMA_TENTHS_DEFAULT = 22;

  // 255^50 < 2^400 covers the widest gamma exponent
  localparam int BIG_W = 400;

  localparam int S_DATA_W = 88;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_LUM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_THR    = 1'b1;

  localparam logic [9:0] BLEND_MAX = 10'd768;
  localparam logic [8:0] ANGLE_MAX = 9'd360;
  localparam logic [8:0] LUM_FULL  = 9'd256;
  localparam logic [3:0] MODE_RING = 4'd1;

  typedef enum logic [1:0] {
    FUNC_UPDATE      = 2'd0,
    FUNC_CLEAR_COLOR = 2'd1,
    FUNC_CLEAR_ALL   = 2'd2,
    FUNC_RESERVED    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CMD_MAIN = 2'd1,
    CMD_PWM  = 2'd2,
    CMD_RGB  = 2'd3
  } cmd_code_t;

  typedef logic [255:0][7:0] gamma_rom_t;

  typedef struct packed {
    logic capture;
    logic clear_color;
    logic clear_pwm;
    logic mul1;
    logic mul2;
    logic decide;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic pend_any;
    logic pend_one;
    logic out_free;
  } ctl_sts_t;

  function automatic logic [BIG_W-1:0] big_pow(int a, int ea, int b, int eb);
    logic [BIG_W-1:0] n;
    n = BIG_W'(1);
    for (int k = 0; k < ea + eb; k++) begin
      n = n * BIG_W'((k < ea) ? a : b);
    end
    return n;
  endfunction

  // floor(255 * (i/255)^(10/tenths)), exact
  function automatic gamma_rom_t gamma_table(int tenths);
    gamma_rom_t t;
    logic [BIG_W-1:0] rhs;
    int v;
    t = '0;
    v = 0;
    for (int i = 1; i < 256; i++) begin
      rhs = big_pow(i, 10, 255, tenths);
      while (v < 255 && big_pow(v + 1, tenths, 255, 10) <= rhs) begin
        v++;
      end
      t[i] = 8'(v);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// ===== design/lce_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lce_ctrl
// Sequencer: input handshake, scaling steps, compare step and command issue.
// ----------------------------------------------------------------------------
module lce_ctrl (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire [lce_pkg::S_USER_W-1:0]   s_tuser,
  input  wire lce_pkg::ctl_sts_t        sts,
  output lce_pkg::ctl_cmd_t             cmd
);
  import lce_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    MUL1,
    MUL2,
    DECIDE,
    EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;
  func_t  func;

  assign func     = func_t'(s_tuser);
  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        cmd.capture     = accept && (func == FUNC_UPDATE);
        cmd.clear_color = accept && (func == FUNC_CLEAR_COLOR || func == FUNC_CLEAR_ALL);
        cmd.clear_pwm   = accept && (func == FUNC_CLEAR_ALL);
        if (accept && func == FUNC_UPDATE) begin
          state_next = MUL1;
        end
      end
      MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = MUL2;
      end
      MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = DECIDE;
      end
      DECIDE: begin
        cmd.decide = 1'b1;
        state_next = EMIT;
      end
      EMIT: begin
        cmd.load_out = sts.pend_any && sts.out_free;
        if (!sts.pend_any || (sts.out_free && sts.pend_one)) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/lce_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lce_dpath
// Gamma, threshold and luminosity scaling lanes, clamps, sent marks and
// the output register.
// ----------------------------------------------------------------------------
module lce_dpath #(
  parameter int GAMMA_TENTHS = lce_pkg::GAMMA_TENTHS_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire lce_pkg::ctl_cmd_t          cmd,
  output lce_pkg::ctl_sts_t               sts,
  input  wire [lce_pkg::S_DATA_W-1:0]     s_tdata,
  input  wire                             cfg_we,
  input  wire [lce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [lce_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [lce_pkg::M_DATA_W-1:0]    m_tdata,
  output logic [lce_pkg::M_USER_W-1:0]    m_tuser,
  output logic                            m_tlast
);
  import lce_pkg::*;

  localparam gamma_rom_t GAMMA = gamma_table(GAMMA_TENTHS);

  logic [8:0]         global_lum;
  logic [7:0]         min_thr;
  logic [8:0]         g_eff;

  // lanes: red, green, blue, main
  logic [3:0][7:0]    lane_in;
  logic [3:0][7:0]    lane_lv;
  logic [3:0][16:0]   prod1;
  logic [3:0][32:0]   prod2;
  logic [3:0][7:0]    scaled;
  logic signed [10:0] blend_req;
  logic signed [9:0]  origin_req;
  logic signed [9:0]  arc_req;
  logic [7:0]         pwm_in;
  logic [15:0]        lum;

  logic [9:0]         blend_c;
  logic [8:0]         origin_c;
  logic [8:0]         arc_c;
  logic [23:0]        color;
  logic               need_rgb;
  logic               need_main;
  logic               need_pwm;

  logic               rgb_sent;
  logic               main_sent;
  logic               pwm_sent;
  logic [23:0]        last_color;
  logic [9:0]         last_blend;
  logic [8:0]         last_origin;
  logic [8:0]         last_arc;
  logic [7:0]         last_main;
  logic [7:0]         last_pwm;
  logic [2:0]         pend;

  logic [7:0]         out_first;
  logic [7:0]         out_second;
  logic [7:0]         out_third;
  logic [31:0]        out_word;
  cmd_code_t          out_cmd;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_lum <= LUM_FULL;
      min_thr    <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GLOBAL_LUM: global_lum <= cfg_data;
        CFG_MIN_THR:    min_thr    <= cfg_data[7:0];
        default:        ;
      endcase
    end
  end

  assign g_eff = global_lum[8] ? LUM_FULL : global_lum;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lane_in[0] <= s_tdata[7:0];
      lane_in[1] <= s_tdata[15:8];
      lane_in[2] <= s_tdata[23:16];
      blend_req  <= s_tdata[34:24];
      origin_req <= s_tdata[44:35];
      arc_req    <= s_tdata[54:45];
      lane_in[3] <= s_tdata[62:55];
      pwm_in     <= s_tdata[70:63];
      lum        <= s_tdata[86:71];
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lane_lv[k] = GAMMA[lane_in[k]];
      if (lane_lv[k] != 8'd0 && lane_lv[k] < min_thr) begin
        lane_lv[k] = min_thr;
      end
    end
    lane_lv[3] = lane_in[3];
    for (int k = 0; k < 4; k++) begin
      prod2[k] = 33'(prod1[k]) * 33'(lum);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (cmd.mul1) begin
        prod1[k] <= 17'(lane_lv[k]) * 17'(g_eff);
      end
      if (cmd.mul2) begin
        scaled[k] <= (|prod2[k][32:24]) ? 8'hFF : prod2[k][23:16];
      end
    end
  end

  always_comb begin
    if (blend_req[10]) begin
      blend_c = '0;
    end else if (blend_req[9:0] > BLEND_MAX) begin
      blend_c = BLEND_MAX;
    end else begin
      blend_c = blend_req[9:0];
    end
    if (origin_req[9]) begin
      origin_c = '0;
    end else if (origin_req[8:0] > ANGLE_MAX) begin
      origin_c = ANGLE_MAX;
    end else begin
      origin_c = origin_req[8:0];
    end
    if (arc_req[9]) begin
      arc_c = '0;
    end else if (arc_req[8:0] > ANGLE_MAX) begin
      arc_c = ANGLE_MAX;
    end else begin
      arc_c = arc_req[8:0];
    end
    color     = {scaled[0], scaled[1], scaled[2]};
    need_rgb  = !rgb_sent || color != last_color || blend_c != last_blend ||
                origin_c != last_origin || arc_c != last_arc;
    need_main = !main_sent || scaled[3] != last_main;
    need_pwm  = !pwm_sent || pwm_in != last_pwm;
  end

  // values that are not resent already equal the last ones sent
  always_ff @(posedge clk) begin
    if (rst) begin
      rgb_sent    <= 1'b0;
      main_sent   <= 1'b0;
      pwm_sent    <= 1'b0;
      last_color  <= '0;
      last_blend  <= '0;
      last_origin <= '0;
      last_arc    <= '0;
      last_main   <= '0;
      last_pwm    <= '0;
      pend        <= '0;
    end else begin
      if (cmd.clear_color) begin
        rgb_sent  <= 1'b0;
        main_sent <= 1'b0;
      end
      if (cmd.clear_pwm) begin
        pwm_sent <= 1'b0;
      end
      if (cmd.decide) begin
        rgb_sent    <= 1'b1;
        main_sent   <= 1'b1;
        pwm_sent    <= 1'b1;
        last_color  <= color;
        last_blend  <= blend_c;
        last_origin <= origin_c;
        last_arc    <= arc_c;
        last_main   <= scaled[3];
        last_pwm    <= pwm_in;
        pend        <= {need_pwm, need_main, need_rgb};
      end else if (cmd.load_out) begin
        pend <= pend & (pend - 3'd1);
      end
    end
  end

  assign sts.pend_any = |pend;
  assign sts.pend_one = (pend & (pend - 3'd1)) == 3'd0;
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_last <= sts.pend_one;
      if (pend[0]) begin
        out_cmd    <= CMD_RGB;
        out_first  <= last_color[23:16];
        out_second <= last_color[15:8];
        out_third  <= last_color[7:0];
        out_word   <= {last_blend, last_origin, last_arc, MODE_RING};
      end else if (pend[1]) begin
        out_cmd    <= CMD_MAIN;
        out_first  <= last_main;
        out_second <= '0;
        out_third  <= '0;
        out_word   <= '0;
      end else begin
        out_cmd    <= CMD_PWM;
        out_first  <= last_pwm;
        out_second <= '0;
        out_third  <= '0;
        out_word   <= '0;
      end
    end
  end

  assign m_tdata = {out_word, out_third, out_second, out_first};
  assign m_tuser = out_cmd;
  assign m_tlast = out_last;

  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("command loaded into a busy output register");

  a_load_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.pend_any)
    else $error("command loaded with nothing pending");

  a_marks_after_decide: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> (rgb_sent && main_sent && pwm_sent))
    else $error("sent marks not set after compare");

endmodule
`default_nettype wire

// ===== design/led_command_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// led_command_encoder_core
// Turns LED parameter updates into RGB, main LED and PWM commands, sending
// each only when its values have changed.
// ----------------------------------------------------------------------------
// One item at a time. An update item runs through the gamma/global multiply,
// the item multiply and the compare step, then issues its commands from one
// output register; each command waits for the output register to drain. The
// next item is taken while the last command still waits to be read.
module led_command_encoder_core #(
  parameter int GAMMA_TENTHS = lce_pkg::GAMMA_TENTHS_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  // red, green, blue, blend_request, origin_request, arc_request,
  // main_level, pwm_level, luminosity_factor, one pad bit
  input  wire [lce_pkg::S_DATA_W-1:0]     s_tdata,
  // func
  input  wire [lce_pkg::S_USER_W-1:0]     s_tuser,
  output logic                            m_tvalid,
  input  wire                             m_tready,
  // first_byte, second_byte, third_byte, packed_word
  output logic [lce_pkg::M_DATA_W-1:0]    m_tdata,
  // command
  output logic [lce_pkg::M_USER_W-1:0]    m_tuser,
  output logic                            m_tlast,
  input  wire                             cfg_we,
  input  wire [lce_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [lce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lce_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  lce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .sts      (sts),
    .cmd      (cmd)
  );

  lce_dpath #(
    .GAMMA_TENTHS (GAMMA_TENTHS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
`default_nettype wire
